// ===== hdl/hpoc_pkg.sv =====
package hpoc_pkg;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 6;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_ORB   = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_HOLE   = 2'd1,
        KIND_PART   = 2'd2,
        KIND_OCC    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SEL_HEADER = 2'd0,
        SEL_LEVEL  = 2'd1,
        SEL_PART   = 2'd2
    } emit_sel_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_HEADER = 5'b00100,
        S_LEVELS = 5'b01000,
        S_PART   = 5'b10000
    } state_t;

    typedef struct packed {
        logic      load;
        logic      start;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      step;
        logic      jump;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic dec;
        logic out_free;
        logic loop_go;
        logic loop_more;
        logic particle;
    } status_t;

endpackage

// ===== hdl/hpoc_ctrl.sv =====
module hpoc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hpoc_pkg::status_t status,
    output hpoc_pkg::cmd_t    cmd
);

    hpoc_pkg::state_t state_reg;
    hpoc_pkg::state_t state_next;
    logic             more_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hpoc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign more_part = (status.op == hpoc_pkg::OP_ORB) && status.particle;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.sel    = hpoc_pkg::SEL_HEADER;
        unique case (state_reg)
            hpoc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hpoc_pkg::S_EVAL;
                end
            end
            hpoc_pkg::S_EVAL:
            begin
                unique case (status.op)
                    hpoc_pkg::OP_START:
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.dec ? hpoc_pkg::S_IDLE : hpoc_pkg::S_HEADER;
                    end
                    hpoc_pkg::OP_ORB:
                    begin
                        if (status.loop_go)
                        begin
                            state_next = hpoc_pkg::S_LEVELS;
                        end
                        else if (status.particle)
                        begin
                            state_next = hpoc_pkg::S_PART;
                        end
                        else
                        begin
                            cmd.jump   = 1'b1;
                            state_next = hpoc_pkg::S_IDLE;
                        end
                    end
                    hpoc_pkg::OP_END:
                    begin
                        state_next = (status.dec && status.loop_go) ?
                                     hpoc_pkg::S_LEVELS : hpoc_pkg::S_IDLE;
                    end
                    default:
                    begin
                        state_next = hpoc_pkg::S_IDLE;
                    end
                endcase
            end
            hpoc_pkg::S_HEADER:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hpoc_pkg::SEL_HEADER;
                    cmd.last   = 1'b1;
                    state_next = hpoc_pkg::S_IDLE;
                end
            end
            hpoc_pkg::S_LEVELS:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hpoc_pkg::SEL_LEVEL;
                    cmd.step = 1'b1;
                    cmd.last = !status.loop_more && !more_part;
                    if (status.loop_more)
                    begin
                        state_next = hpoc_pkg::S_LEVELS;
                    end
                    else if (more_part)
                    begin
                        state_next = hpoc_pkg::S_PART;
                    end
                    else
                    begin
                        cmd.jump   = (status.op == hpoc_pkg::OP_ORB);
                        state_next = hpoc_pkg::S_IDLE;
                    end
                end
            end
            hpoc_pkg::S_PART:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hpoc_pkg::SEL_PART;
                    cmd.last   = 1'b1;
                    cmd.jump   = 1'b1;
                    state_next = hpoc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hpoc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/hpoc_dp.sv =====
module hpoc_dp
#(
    parameter int MAX_ELECTRONS = 32,
    parameter int ORBITAL_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic [hpoc_pkg::VALUE_W-1:0] s_tdata,
    input  logic [hpoc_pkg::OP_W-1:0]    s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hpoc_pkg::VALUE_W-1:0] m_tdata,
    output logic [hpoc_pkg::KIND_W-1:0]  m_tuser,
    output logic                         m_tlast,
    input  hpoc_pkg::cmd_t               cmd,
    output hpoc_pkg::status_t            status
);

    localparam int VW = hpoc_pkg::VALUE_W;
    localparam int CW = hpoc_pkg::COUNT_W;

    logic                      dir_reg;
    hpoc_pkg::op_t             op_reg;
    logic [VW-1:0]             val_reg;
    logic [VW-1:0]             level_reg;
    logic [CW-1:0]             count_reg;
    logic                      valid_reg;
    logic [VW-1:0]             data_reg;
    hpoc_pkg::kind_t           kind_reg;
    logic                      last_reg;

    logic [VW-1:0]             orb;
    logic [VW-1:0]             count_ext;
    logic [VW-1:0]             level_inc;
    logic [VW:0]               orb_inc;
    logic [VW-1:0]             orb_sat;
    logic [CW-1:0]             count_sat;
    logic [VW-1:0]             emit_data;
    hpoc_pkg::kind_t           emit_kind;

    always_comb
    begin
        for (int i = 0; i < VW; i++)
        begin
            orb[i] = (i < ORBITAL_BITS) ? val_reg[i] : 1'b0;
        end
    end

    assign count_ext = VW'(count_reg);
    assign level_inc = level_reg + VW'(1);
    assign orb_inc   = {1'b0, orb} + (VW+1)'(1);
    assign orb_sat   = orb_inc[VW] ? '1 : orb_inc[VW-1:0];
    assign count_sat = (val_reg > VW'(MAX_ELECTRONS)) ? CW'(MAX_ELECTRONS) : val_reg[CW-1:0];

    assign status.op        = op_reg;
    assign status.dec       = dir_reg;
    assign status.out_free  = !valid_reg || m_tready;
    assign status.particle  = (orb >= count_ext);
    assign status.loop_go   = (level_reg < count_ext) &&
                              ((op_reg == hpoc_pkg::OP_END) || (level_reg < orb));
    assign status.loop_more = (level_inc < count_ext) &&
                              ((op_reg == hpoc_pkg::OP_END) || (level_inc < orb));

    always_comb
    begin
        case (cmd.sel)
            hpoc_pkg::SEL_HEADER:
            begin
                emit_data = count_ext;
                emit_kind = hpoc_pkg::KIND_HEADER;
            end
            hpoc_pkg::SEL_LEVEL:
            begin
                emit_data = level_reg;
                emit_kind = dir_reg ? hpoc_pkg::KIND_OCC : hpoc_pkg::KIND_HOLE;
            end
            hpoc_pkg::SEL_PART:
            begin
                emit_data = orb;
                emit_kind = dir_reg ? hpoc_pkg::KIND_OCC : hpoc_pkg::KIND_PART;
            end
            default:
            begin
                emit_data = orb;
                emit_kind = hpoc_pkg::KIND_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 1'b0;
            op_reg    <= hpoc_pkg::OP_NONE;
            level_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                op_reg <= hpoc_pkg::op_t'(s_tuser);
            end
            if (cmd.start)
            begin
                count_reg <= count_sat;
                level_reg <= '0;
            end
            else if (cmd.jump)
            begin
                level_reg <= orb_sat;
            end
            else if (cmd.step)
            begin
                level_reg <= level_inc;
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= s_tdata;
        end
        if (cmd.emit)
        begin
            data_reg <= emit_data;
            kind_reg <= emit_kind;
            last_reg <= cmd.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/hole_particle_occupancy_codec_top.sv =====
// Hole/particle occupancy codec.
// Input stream: s_tuser carries the operation (start, orbital/code word, end),
// s_tdata the electron count or orbital index. Output stream: m_tdata carries
// the emitted index, m_tuser its kind (header, hole, particle, occupied), and
// m_tlast marks the last result of each input request.
// cfg_we/cfg_wdata set the direction (0 encode, 1 decode); write only while idle.
// Timing: a request is taken while the controller is idle and decoded in the
// cycle after; then each result leaves the output register at one per cycle
// while m_tready stays high. s_tready is high only while the controller waits
// for a request.
// Reset clears direction, electron count and next level, and empties the
// output register. When the receiver holds m_tready low, the finished result
// stays in the output register and the controller waits before the next emit;
// a request already taken is held until its last result is in the register.
module hole_particle_occupancy_codec_top
#(
    parameter int MAX_ELECTRONS = 32,
    parameter int ORBITAL_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hpoc_pkg::VALUE_W-1:0] s_tdata,   // [15:0] value
    input  logic [hpoc_pkg::OP_W-1:0]    s_tuser,   // [1:0] operation
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hpoc_pkg::VALUE_W-1:0] m_tdata,   // [15:0] value_res
    output logic [hpoc_pkg::KIND_W-1:0]  m_tuser,   // [1:0] kind
    output logic                         m_tlast
);

    hpoc_pkg::cmd_t    cmd;
    hpoc_pkg::status_t status;

    hpoc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hpoc_dp
    #(
        .MAX_ELECTRONS (MAX_ELECTRONS),
        .ORBITAL_BITS  (ORBITAL_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_N     = 32;
    localparam int ORB_BITS  = 16;
    localparam int LEVEL_TOP = 65535;

    typedef struct {
        logic [hpoc_pkg::VALUE_W-1:0] value;
        hpoc_pkg::kind_t              kind;
        logic                         last;
    } code_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic                         cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [hpoc_pkg::VALUE_W-1:0] s_tdata;
    logic [hpoc_pkg::OP_W-1:0]    s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [hpoc_pkg::VALUE_W-1:0] m_tdata;
    logic [hpoc_pkg::KIND_W-1:0]  m_tuser;
    logic                         m_tlast;

    // predictor state
    logic       decode_mode;
    int         next_lvl;
    int         n_elec;
    code_word_t codes_due[$];

    int  src_idle_pct;
    int  snk_stall_pct;
    logic hold_off;
    int  fails;
    int  requests;
    int  results;
    int  kind_seen[4];
    code_word_t want;

    always #5 clk = ~clk;

    hole_particle_occupancy_codec_top #(
        .MAX_ELECTRONS (MAX_N),
        .ORBITAL_BITS  (ORB_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic void push_code(int value, hpoc_pkg::kind_t kind);
        code_word_t c;
        c.value = value[hpoc_pkg::VALUE_W-1:0];
        c.kind  = kind;
        c.last  = 1'b0;
        codes_due = {codes_due, c};
    endfunction

    function automatic void predict_codes(hpoc_pkg::op_t op,
                                          logic [hpoc_pkg::VALUE_W-1:0] v);
        int orb;
        int sz0;
        sz0 = codes_due.size();
        case (op)
            hpoc_pkg::OP_START:
            begin
                n_elec   = (int'(v) > MAX_N) ? MAX_N : int'(v);
                next_lvl = 0;
                if (!decode_mode)
                    push_code(n_elec, hpoc_pkg::KIND_HEADER);
            end
            hpoc_pkg::OP_ORB:
            begin
                orb = int'(v) & ((1 << ORB_BITS) - 1);
                while (next_lvl < n_elec && next_lvl < orb)
                begin
                    push_code(next_lvl, decode_mode ? hpoc_pkg::KIND_OCC : hpoc_pkg::KIND_HOLE);
                    next_lvl++;
                end
                if (orb >= n_elec)
                    push_code(orb, decode_mode ? hpoc_pkg::KIND_OCC : hpoc_pkg::KIND_PART);
                next_lvl = (orb + 1 > LEVEL_TOP) ? LEVEL_TOP : orb + 1;
            end
            hpoc_pkg::OP_END:
            begin
                if (decode_mode)
                begin
                    while (next_lvl < n_elec)
                    begin
                        push_code(next_lvl, hpoc_pkg::KIND_OCC);
                        next_lvl++;
                    end
                end
            end
            default: ;
        endcase
        if (codes_due.size() > sz0)
            codes_due[codes_due.size()-1].last = 1'b1;
    endfunction

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results++;
            kind_seen[m_tuser]++;
            if (codes_due.size() == 0)
            begin
                $error("unexpected result: value_res=%0d kind=%0d run_last=%0b",
                       m_tdata, m_tuser, m_tlast);
                fails++;
            end
            else
            begin
                want = codes_due.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("value_res: expected %0d, got %0d", want.value, m_tdata);
                    fails++;
                end
                if (m_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    fails++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("run_last: expected %0b, got %0b", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    task automatic send_req(input hpoc_pkg::op_t op, input logic [hpoc_pkg::VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        predict_codes(op, v);
        if (op != hpoc_pkg::OP_NONE)
            requests++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (codes_due.size() != 0)
            @(posedge clk);
        // requests with no results may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        decode_mode = d;
    endtask

    task automatic send_determinant();
        int   n;
        int   cnt;
        int   pos;
        int   pick;
        logic broken;
        logic [1:0] rop;
        broken = ($urandom_range(0, 99) < 15);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            n = $urandom_range(0, 10);
        else if (pick < 9)
            n = $urandom_range(11, 32);
        else
            n = $urandom_range(33, 65535);
        if (!broken || $urandom_range(0, 1))
            send_req(hpoc_pkg::OP_START, n[hpoc_pkg::VALUE_W-1:0]);
        pos = $urandom_range(0, 2);
        cnt = $urandom_range(0, 7);
        for (int i = 0; i < cnt; i++)
        begin
            if (broken && $urandom_range(0, 2) == 0)
            begin
                rop = 2'($urandom_range(0, 3));
                send_req(hpoc_pkg::op_t'(rop), 16'($urandom_range(0, 65535)));
            end
            else if (broken && $urandom_range(0, 2) == 0)
                send_req(hpoc_pkg::OP_ORB, 16'($urandom_range(0, pos)));   // out of order
            else
            begin
                if (pos > LEVEL_TOP)
                    break;
                send_req(hpoc_pkg::OP_ORB, pos[hpoc_pkg::VALUE_W-1:0]);
                if ($urandom_range(0, 15) == 0)
                    pos = $urandom_range(pos + 1, LEVEL_TOP + 1);
                else
                    pos += $urandom_range(1, 4);
            end
        end
        if (!broken || $urandom_range(0, 1))
            send_req(hpoc_pkg::OP_END, 16'($urandom_range(0, 65535)));
    endtask

    task automatic test_encode_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_req(hpoc_pkg::OP_ORB, 16'd5);          // no start after reset
        send_req(hpoc_pkg::OP_START, 16'hFFFF);     // count saturates
        send_req(hpoc_pkg::OP_ORB, 16'd40);         // full set of holes plus particle
        send_req(hpoc_pkg::OP_END, 16'd0);
        send_req(hpoc_pkg::OP_START, 16'd3);
        send_req(hpoc_pkg::OP_ORB, 16'd1);
        send_req(hpoc_pkg::OP_ORB, 16'd0);          // out of order, nothing emitted
        send_req(hpoc_pkg::OP_ORB, 16'd2);
        send_req(hpoc_pkg::OP_NONE, 16'hFFFF);
        send_req(hpoc_pkg::OP_ORB, 16'hFFFF);       // level saturates
        send_req(hpoc_pkg::OP_ORB, 16'hFFFE);
        send_req(hpoc_pkg::OP_START, 16'd0);
        send_req(hpoc_pkg::OP_ORB, 16'd0);
    endtask

    task automatic test_decode_directed();
        set_direction(1'b1);
        send_req(hpoc_pkg::OP_START, 16'd4);
        send_req(hpoc_pkg::OP_ORB, 16'd2);
        send_req(hpoc_pkg::OP_ORB, 16'd6);
        send_req(hpoc_pkg::OP_END, 16'hFFFF);
        send_req(hpoc_pkg::OP_START, 16'd5);
        send_req(hpoc_pkg::OP_ORB, 16'd1);
        send_req(hpoc_pkg::OP_END, 16'd0);
        send_req(hpoc_pkg::OP_END, 16'd0);
        send_req(hpoc_pkg::OP_START, 16'd32);
        send_req(hpoc_pkg::OP_END, 16'hAAAA);       // flushes every level
        send_req(hpoc_pkg::OP_ORB, 16'h5555);
        send_req(hpoc_pkg::OP_NONE, 16'h0000);
    endtask

    task automatic test_output_stall();
        set_direction(1'b0);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                send_req(hpoc_pkg::OP_START, 16'd32);
                send_req(hpoc_pkg::OP_ORB, 16'd40);
                send_req(hpoc_pkg::OP_START, 16'd20);
                send_req(hpoc_pkg::OP_ORB, 16'd25);
                send_req(hpoc_pkg::OP_END, 16'd0);
            end
        join
    endtask

    task automatic test_random(input int src_pct, input int snk_pct, input int n_items);
        int target;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int d = 0; d < 2; d++)
        begin
            set_direction(d[0]);
            target = requests + n_items / 2;
            while (requests < target)
                send_determinant();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        hold_off      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        decode_mode   = 1'b0;
        next_lvl      = 0;
        n_elec        = 0;
        fails         = 0;
        requests      = 0;
        results       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_output_stall();
        test_random(0, 0, 84);
        test_random(62, 0, 84);
        test_random(0, 62, 84);
        test_random(29, 29, 84);
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests and %0d results: %0d headers, %0d holes, %0d particles,",
                 requests, results, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d occupied levels; encode and decode under four pacing mixes and a long stall.",
                 kind_seen[3]);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
